/* rtl/core/assert_macros.svh */
// Assertion macros shared by the decoder RTL.
// Each macro expands to one labeled concurrent assertion, clocked and reset-qualified.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/core/ibwt_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the inverse BWT decoder.
// Depends on nothing; used by ibwt_symtab, ibwt_ctrl and inverse_bwt_decoder.
package ibwt_pkg;

  localparam int unsigned BlockMaxDefault = 4096;
  localparam int unsigned SymbolsDefault  = 256;
  localparam int unsigned ByteW           = 8;
  localparam int unsigned PosW            = 12;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_REQUEST = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_BLOCK  = 2'd1,
    STATUS_BAD_INDEX = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PH_LOADING  = 2'd0,
    PH_DECODING = 2'd1,
    PH_FINISHED = 2'd2
  } phase_e;

  typedef struct packed {
    logic wr_en;
    logic clear_all;
  } symtab_ctl_t;

endpackage

/* rtl/core/ibwt_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module ibwt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/ibwt_symtab.sv */
`timescale 1ns / 1ps
// Per-symbol table holding counts while loading and symbol starts while decoding.
// Depends on ibwt_pkg, ibwt_ram and assert_macros.svh.
`include "assert_macros.svh"
module ibwt_symtab import ibwt_pkg::*; #(
  parameter int unsigned SYMBOLS = SymbolsDefault,
  parameter int unsigned CntW = 13,
  localparam int unsigned SymW = $clog2(SYMBOLS)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  symtab_ctl_t     ctl_i,
  input  logic [SymW-1:0] waddr_i,
  input  logic [CntW-1:0] wdata_i,
  input  logic [SymW-1:0] raddr_i,
  output logic [CntW-1:0] rdata_o
);

  logic [SYMBOLS-1:0] valid_q;
  logic [SymW-1:0]    raddr_q;
  logic [CntW-1:0]    ram_rdata;

  ibwt_ram #(
    .Width(CntW),
    .Depth(SYMBOLS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ctl_i.wr_en),
    .waddr_i(waddr_i),
    .wdata_i(wdata_i),
    .raddr_i(raddr_i),
    .rdata_o(ram_rdata)
  );

  // An entry never written since the last clear reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctl_i.clear_all) begin
      valid_q <= '0;
    end else if (ctl_i.wr_en) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q <= raddr_i;
  end

  assign rdata_o = valid_q[raddr_q] ? ram_rdata : '0;

  `ASSERT_NEVER(a_clear_with_write, clk_i, rst_ni, ctl_i.clear_all && ctl_i.wr_en,
                "symbol table cleared and written in the same cycle")

endmodule

/* rtl/core/ibwt_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer of the inverse BWT decoder: load, prefix-sum sweep and LF walk.
// Depends on ibwt_pkg and assert_macros.svh; drives the block RAM and symbol table.
`include "assert_macros.svh"
module ibwt_ctrl import ibwt_pkg::*; #(
  parameter int unsigned BLOCK_MAX = BlockMaxDefault,
  parameter int unsigned SYMBOLS = SymbolsDefault,
  localparam int unsigned RowW  = $clog2(BLOCK_MAX),
  localparam int unsigned LenW  = $clog2(BLOCK_MAX + 1),
  localparam int unsigned CntW  = LenW,
  localparam int unsigned SymW  = $clog2(SYMBOLS),
  localparam int unsigned DatW  = SymW + RowW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              operation_i,
  input  logic [ByteW-1:0]  bwt_byte_i,
  input  logic [11:0]       primary_index_i,
  input  logic              last_byte_i,
  output logic              valid_o,
  output logic [ByteW-1:0]  out_byte_o,
  output logic [PosW-1:0]   out_position_o,
  output logic              block_done_o,
  output logic [1:0]        status_o,
  output logic              dat_we_o,
  output logic [RowW-1:0]   dat_waddr_o,
  output logic [DatW-1:0]   dat_wdata_o,
  output logic [RowW-1:0]   dat_raddr_o,
  input  logic [DatW-1:0]   dat_rdata_i,
  output symtab_ctl_t       sym_ctl_o,
  output logic [SymW-1:0]   sym_waddr_o,
  output logic [CntW-1:0]   sym_wdata_o,
  output logic [SymW-1:0]   sym_raddr_o,
  input  logic [CntW-1:0]   sym_rdata_i
);

  localparam int unsigned WalkW = (RowW > 12) ? RowW : 12;
  localparam int unsigned CmpW  = WalkW + 1;
  localparam int unsigned SwW   = $clog2(SYMBOLS + 1);

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_LOAD      = 5'b00010,
    ST_SWEEP     = 5'b00100,
    ST_WALK_SYM  = 5'b01000,
    ST_WALK_NEXT = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [LenW-1:0]   block_length_q, block_length_d;
  logic [LenW-1:0]   bytes_left_q, bytes_left_d;
  logic [WalkW-1:0]  walk_row_q, walk_row_d;
  logic              valid_q, valid_d;

  logic [SymW-1:0]   sym_q, sym_d;
  logic [RowW-1:0]   wr_row_q, wr_row_d;
  logic              store_q, store_d;
  logic              last_q, last_d;
  logic [RowW-1:0]   rank_q, rank_d;
  logic [SwW-1:0]    sweep_cnt_q, sweep_cnt_d;
  logic [CntW-1:0]   sum_q, sum_d;
  logic [PosW-1:0]   pend_pos_q, pend_pos_d;
  logic              pend_done_q, pend_done_d;
  logic [ByteW-1:0]  out_byte_q, out_byte_d;
  logic [PosW-1:0]   out_pos_q, out_pos_d;
  logic              out_done_q, out_done_d;
  status_e           status_q, status_d;

  logic              accept;
  logic [SymW-1:0]   in_sym;
  logic [SymW-1:0]   rd_sym;
  logic [RowW-1:0]   rd_rank;
  logic [CntW:0]     next_sum;
  logic [WalkW-1:0]  next_row;
  logic [WalkW-1:0]  walk_row_cur;
  logic [LenW-1:0]   len_base;
  logic              store_ok;
  logic              no_block;
  logic              bad_index;
  logic [LenW-1:0]   pos;

  assign busy_o = !(state_q == ST_IDLE || state_q == ST_WALK_NEXT);
  assign accept = start_i && !busy_o;

  assign in_sym = ({1'b0, bwt_byte_i} < 9'(SYMBOLS)) ? SymW'(bwt_byte_i)
                                                     : SymW'(SYMBOLS - 1);
  assign rd_sym  = dat_rdata_i[DatW-1:RowW];
  assign rd_rank = dat_rdata_i[RowW-1:0];

  assign next_sum     = {1'b0, sym_rdata_i} + (CntW + 1)'(rank_q);
  assign next_row     = (next_sum < (CntW + 1)'(block_length_q)) ? WalkW'(next_sum) : '0;
  assign walk_row_cur = (state_q == ST_WALK_NEXT) ? next_row : walk_row_q;

  assign len_base  = (phase_q != PH_LOADING) ? '0 : block_length_q;
  assign store_ok  = len_base < LenW'(BLOCK_MAX);
  assign no_block  = (phase_q != PH_DECODING) || (bytes_left_q == '0);
  assign bad_index = CmpW'(walk_row_cur) >= CmpW'(block_length_q);
  assign pos       = bytes_left_q - LenW'(1);

  assign dat_raddr_o = walk_row_cur[RowW-1:0];

  always_comb begin
    state_d        = state_q;
    phase_d        = phase_q;
    block_length_d = block_length_q;
    bytes_left_d   = bytes_left_q;
    walk_row_d     = walk_row_q;
    valid_d        = 1'b0;
    sym_d          = sym_q;
    wr_row_d       = wr_row_q;
    store_d        = store_q;
    last_d         = last_q;
    rank_d         = rank_q;
    sweep_cnt_d    = sweep_cnt_q;
    sum_d          = sum_q;
    pend_pos_d     = pend_pos_q;
    pend_done_d    = pend_done_q;
    out_byte_d     = out_byte_q;
    out_pos_d      = out_pos_q;
    out_done_d     = out_done_q;
    status_d       = status_q;

    dat_we_o    = 1'b0;
    dat_waddr_o = wr_row_q;
    dat_wdata_o = {sym_q, sym_rdata_i[RowW-1:0]};
    sym_ctl_o   = '0;
    sym_waddr_o = sym_q;
    sym_wdata_o = sym_rdata_i + CntW'(1);
    sym_raddr_o = in_sym;

    unique case (state_q)
      ST_IDLE: begin
      end
      ST_LOAD: begin
        if (store_q) begin
          dat_we_o        = 1'b1;
          sym_ctl_o.wr_en = 1'b1;
        end
        sweep_cnt_d = '0;
        sum_d       = '0;
        state_d     = last_q ? ST_SWEEP : ST_IDLE;
      end
      ST_SWEEP: begin
        sym_raddr_o = SymW'(sweep_cnt_q);
        if (sweep_cnt_q != '0) begin
          sym_ctl_o.wr_en = 1'b1;
          sym_waddr_o     = SymW'(sweep_cnt_q - SwW'(1));
          sym_wdata_o     = sum_q;
          sum_d           = sum_q + sym_rdata_i;
        end
        if (sweep_cnt_q == SwW'(SYMBOLS)) begin
          state_d = ST_IDLE;
        end else begin
          sweep_cnt_d = sweep_cnt_q + SwW'(1);
        end
      end
      ST_WALK_SYM: begin
        sym_raddr_o = rd_sym;
        rank_d      = rd_rank;
        valid_d     = 1'b1;
        out_byte_d  = ByteW'(rd_sym);
        out_pos_d   = pend_pos_q;
        out_done_d  = pend_done_q;
        status_d    = STATUS_OK;
        state_d     = ST_WALK_NEXT;
      end
      ST_WALK_NEXT: begin
        walk_row_d = next_row;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (accept) begin
      if (operation_i == OP_LOAD) begin
        if (phase_q != PH_LOADING) begin
          sym_ctl_o.clear_all = 1'b1;
        end
        block_length_d = len_base + LenW'(store_ok);
        store_d        = store_ok;
        wr_row_d       = RowW'(len_base);
        sym_d          = in_sym;
        last_d         = last_byte_i;
        state_d        = ST_LOAD;
        if (last_byte_i) begin
          phase_d      = PH_DECODING;
          walk_row_d   = WalkW'(primary_index_i);
          bytes_left_d = len_base + LenW'(store_ok);
        end else begin
          phase_d = PH_LOADING;
        end
      end else if (no_block) begin
        valid_d    = 1'b1;
        out_byte_d = '0;
        out_pos_d  = '0;
        out_done_d = 1'b0;
        status_d   = STATUS_NO_BLOCK;
      end else if (bad_index) begin
        valid_d    = 1'b1;
        out_byte_d = '0;
        out_pos_d  = '0;
        out_done_d = 1'b0;
        status_d   = STATUS_BAD_INDEX;
        phase_d    = PH_FINISHED;
      end else begin
        bytes_left_d = pos;
        pend_pos_d   = PosW'(pos);
        pend_done_d  = (pos == '0);
        if (pos == '0) begin
          phase_d = PH_FINISHED;
        end
        state_d = ST_WALK_SYM;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      phase_q        <= PH_LOADING;
      block_length_q <= '0;
      bytes_left_q   <= '0;
      walk_row_q     <= '0;
      valid_q        <= 1'b0;
    end else begin
      state_q        <= state_d;
      phase_q        <= phase_d;
      block_length_q <= block_length_d;
      bytes_left_q   <= bytes_left_d;
      walk_row_q     <= walk_row_d;
      valid_q        <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q       <= sym_d;
    wr_row_q    <= wr_row_d;
    store_q     <= store_d;
    last_q      <= last_d;
    rank_q      <= rank_d;
    sweep_cnt_q <= sweep_cnt_d;
    sum_q       <= sum_d;
    pend_pos_q  <= pend_pos_d;
    pend_done_q <= pend_done_d;
    out_byte_q  <= out_byte_d;
    out_pos_q   <= out_pos_d;
    out_done_q  <= out_done_d;
    status_q    <= status_d;
  end

  assign valid_o        = valid_q;
  assign out_byte_o     = out_byte_q;
  assign out_position_o = out_pos_q;
  assign block_done_o   = out_done_q;
  assign status_o       = status_q;

  `ASSERT_CLK(a_walk_gives_word, clk_i, rst_ni,
              state_q == ST_WALK_SYM |=> valid_q && status_q == STATUS_OK,
              "walk step did not deliver a good word")
  `ASSERT_CLK(a_sweep_quiet, clk_i, rst_ni,
              state_q == ST_SWEEP |-> !valid_q && phase_q == PH_DECODING,
              "sweep overlaps a result or runs outside decoding")
  `ASSERT_CLK(a_bytes_within_block, clk_i, rst_ni,
              phase_q == PH_DECODING |-> bytes_left_q <= block_length_q,
              "more bytes left than the block holds")
  `ASSERT_CLK(a_length_bound, clk_i, rst_ni,
              block_length_q <= LenW'(BLOCK_MAX),
              "block length beyond capacity")

endmodule

/* rtl/core/inverse_bwt_decoder.sv */
`timescale 1ns / 1ps
// Top level of the inverse BWT decoder: sequencer, block RAM and symbol table.
// Depends on ibwt_pkg, ibwt_ram, ibwt_symtab and ibwt_ctrl.
//
// A word is taken when start_i is high and busy_o is low. A load word keeps
// busy_o high in ST_LOAD; the load word marked last also sweeps the symbol
// table in ST_SWEEP to form symbol starts, with busy_o high. A request word
// gives exactly one result word with valid_o high for one cycle: an error
// result in the cycle after the request, a decoded byte after ST_WALK_SYM. A
// good request keeps busy_o high only in ST_WALK_SYM, so a new request can be
// taken in ST_WALK_NEXT; decoded bytes are paced by the dependent reads of the
// block RAM and then the symbol table. There is no way to hold results off;
// the receiver must take each word in the cycle it is shown. Bytes come out
// from the last block position down to position 0, flagged by block_done_o.
module inverse_bwt_decoder import ibwt_pkg::*; #(
  parameter int unsigned BLOCK_MAX = BlockMaxDefault,
  parameter int unsigned SYMBOLS = SymbolsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic             operation_i,
  input  logic [ByteW-1:0] bwt_byte_i,
  input  logic [11:0]      primary_index_i,
  input  logic             last_byte_i,
  output logic             valid_o,
  output logic [ByteW-1:0] out_byte_o,
  output logic [PosW-1:0]  out_position_o,
  output logic             block_done_o,
  output logic [1:0]       status_o
);

  localparam int unsigned RowW = $clog2(BLOCK_MAX);
  localparam int unsigned CntW = $clog2(BLOCK_MAX + 1);
  localparam int unsigned SymW = $clog2(SYMBOLS);
  localparam int unsigned DatW = SymW + RowW;

  logic            dat_we;
  logic [RowW-1:0] dat_waddr;
  logic [DatW-1:0] dat_wdata;
  logic [RowW-1:0] dat_raddr;
  logic [DatW-1:0] dat_rdata;
  symtab_ctl_t     sym_ctl;
  logic [SymW-1:0] sym_waddr;
  logic [CntW-1:0] sym_wdata;
  logic [SymW-1:0] sym_raddr;
  logic [CntW-1:0] sym_rdata;

  ibwt_ram #(
    .Width(DatW),
    .Depth(BLOCK_MAX)
  ) u_block_ram (
    .clk_i  (clk_i),
    .we_i   (dat_we),
    .waddr_i(dat_waddr),
    .wdata_i(dat_wdata),
    .raddr_i(dat_raddr),
    .rdata_o(dat_rdata)
  );

  ibwt_symtab #(
    .SYMBOLS(SYMBOLS),
    .CntW   (CntW)
  ) u_symtab (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (sym_ctl),
    .waddr_i(sym_waddr),
    .wdata_i(sym_wdata),
    .raddr_i(sym_raddr),
    .rdata_o(sym_rdata)
  );

  ibwt_ctrl #(
    .BLOCK_MAX(BLOCK_MAX),
    .SYMBOLS  (SYMBOLS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .operation_i    (operation_i),
    .bwt_byte_i     (bwt_byte_i),
    .primary_index_i(primary_index_i),
    .last_byte_i    (last_byte_i),
    .valid_o        (valid_o),
    .out_byte_o     (out_byte_o),
    .out_position_o (out_position_o),
    .block_done_o   (block_done_o),
    .status_o       (status_o),
    .dat_we_o       (dat_we),
    .dat_waddr_o    (dat_waddr),
    .dat_wdata_o    (dat_wdata),
    .dat_raddr_o    (dat_raddr),
    .dat_rdata_i    (dat_rdata),
    .sym_ctl_o      (sym_ctl),
    .sym_waddr_o    (sym_waddr),
    .sym_wdata_o    (sym_wdata),
    .sym_raddr_o    (sym_raddr),
    .sym_rdata_i    (sym_rdata)
  );

endmodule
